### hw/rtl/blpd_pkg.sv
// Shared constants for the bounded list block: field widths, command and
// status codes, and default capacity. No dependencies.
package blpd_pkg;

   localparam int CAPACITY_DEF = 64;

   localparam int CMD_W  = 3;
   localparam int DATA_W = 32;
   localparam int POS_W  = 7;
   localparam int LEN_W  = 7;
   localparam int STAT_W = 2;

   localparam logic [CMD_W-1:0] CMD_APPEND   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DEL_HEAD = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DEL_TAIL = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEL_POS  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ_POS = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
   localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

endpackage

### hw/rtl/bounded_list_positional_delete.sv
// Bounded ordered list of signed 32-bit values kept in one RAM.
// Append, delete last and every rejected command go from transfer straight to
// the result state; read at position waits for one RAM read.
// Delete first / at position walk the tail through the single RAM read port.
// One command at a time.
// Reset clears the element count and control state; RAM contents are kept.
module bounded_list_positional_delete
   import blpd_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // command channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CMD_W-1:0]         req_cmd,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic [POS_W-1:0]         req_position,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [STAT_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic [LEN_W-1:0]         rsp_length
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_SHIFT = 4'b0010,
      S_RDWT  = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         src_ff, src_in;
   logic                     wr_pend_ff, wr_pend_in;
   logic [ADDR_W-1:0]        wr_addr_ff, wr_addr_in;
   logic [STAT_W-1:0]        res_status_ff, res_status_in;
   logic signed [DATA_W-1:0] res_value_ff, res_value_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [LEN_W-1:0]         rsp_length_ff, rsp_length_in;

   logic                     req_xfer;
   logic                     out_free;
   logic                     pos_ok;
   logic                     is_empty;
   logic                     is_full;
   logic                     rd_go;
   logic                     ram_we;
   logic [ADDR_W-1:0]        ram_waddr;
   logic [DATA_W-1:0]        ram_wdata;
   logic [ADDR_W-1:0]        ram_raddr;
   logic [DATA_W-1:0]        ram_rdata;

   blpd_ram #(
      .WIDTH(DATA_W),
      .DEPTH(CAPACITY)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // accept only while idle
   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff >= CNT_W'(CAPACITY));
   assign pos_ok   = (req_position != '0) &&
                     (CMP_W'(req_position) <= CMP_W'(count_ff));
   assign rd_go    = (src_ff <= count_ff);

   // read address: requested slot while idle, next source while shifting
   assign ram_raddr = (state_ff == S_SHIFT) ? ADDR_W'(src_ff)
                                            : ADDR_W'(req_position - POS_W'(1));

   // write port: pending move while shifting, else append at the tail
   always_comb begin
      if (state_ff == S_SHIFT) begin
         ram_we    = wr_pend_ff;
         ram_waddr = wr_addr_ff;
         ram_wdata = ram_rdata;
      end else begin
         ram_we    = req_xfer && (req_cmd == CMD_APPEND) && !is_full;
         ram_waddr = ADDR_W'(count_ff);
         ram_wdata = req_value;
      end
   end

   // command sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      src_in        = src_ff;
      wr_pend_in    = 1'b0;
      wr_addr_in    = wr_addr_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_length_in = rsp_length_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               res_status_in = ST_OK;
               res_value_in  = '0;
               state_in      = S_DONE;
               case (req_cmd)
                  CMD_APPEND: begin
                     if (is_full) begin
                        res_status_in = ST_FULL;
                     end else begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_DEL_HEAD: begin
                     if (is_empty) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                        src_in   = CNT_W'(1);
                        state_in = S_SHIFT;
                     end
                  end
                  CMD_DEL_TAIL: begin
                     if (is_empty) begin
                        res_status_in = ST_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  CMD_DEL_POS: begin
                     if (is_empty) begin
                        res_status_in = ST_EMPTY;
                     end else if (!pos_ok) begin
                        res_status_in = ST_INVALID;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                        src_in   = CNT_W'(req_position);
                        state_in = S_SHIFT;
                     end
                  end
                  CMD_READ_POS: begin
                     if (!pos_ok) begin
                        res_status_in = ST_INVALID;
                     end else begin
                        state_in = S_RDWT;
                     end
                  end
                  default: begin
                     res_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_SHIFT: begin
            // read slot src now, write it one place toward the head next cycle
            if (rd_go) begin
               src_in     = src_ff + CNT_W'(1);
               wr_pend_in = 1'b1;
               wr_addr_in = ADDR_W'(src_ff - CNT_W'(1));
            end else begin
               state_in = S_DONE;
            end
         end
         S_RDWT: begin
            res_value_in = ram_rdata;
            state_in     = S_DONE;
         end
         S_DONE: begin
            // hand the result to the output register once it is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_length_in = LEN_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      src_ff        <= src_in;
      wr_addr_ff    <= wr_addr_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_length     = rsp_length_ff;

   // element count never exceeds capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   // a move during a shift always lands inside the shortened list
   a_shift_addr: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> (CNT_W'(wr_addr_ff) < count_ff))
      else $error("shift write outside list");

   // a successful append grows the list by exactly one
   a_append_grow: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_cmd == CMD_APPEND && !is_full) |=>
      (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("append did not grow list");

   // during a shift the RAM write port carries only the pending move
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> !ram_we || (ram_waddr == wr_addr_ff))
      else $error("write port conflict during shift");

endmodule

### hw/rtl/blpd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module blpd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
